// ===== rtl/core/xtea_wk_pkg.sv =====
// Shared types, constants and round functions for the wide-key XTEA core.
// Used by xtea_wk_cfg, xtea_wk_stage and xtea_wide_key_block_cipher_top.
`timescale 1ns / 1ps

package xtea_wk_pkg;

  localparam logic [31:0] XWK_DELTA  = 32'h9E37_79B9;
  localparam int          XWK_ADDR_W = 6;
  localparam int          XWK_DATA_W = 64;

  // Register indexes (byte address bits [5:3])
  localparam logic [2:0] XWK_REG_KEY_1_0 = 3'd0;
  localparam logic [2:0] XWK_REG_KEY_3_2 = 3'd1;
  localparam logic [2:0] XWK_REG_KEY_5_4 = 3'd2;
  localparam logic [2:0] XWK_REG_KEY_7_6 = 3'd3;
  localparam logic [2:0] XWK_REG_ROUNDS  = 3'd4;

  localparam logic [7:0] XWK_ROUNDS_RST = 8'd32;

  localparam logic XWK_OP_ENC = 1'b0;
  localparam logic XWK_OP_DEC = 1'b1;

  typedef logic [7:0][31:0] xwk_keys_t;

  // Block state that travels down the pipeline
  typedef struct packed {
    logic        op;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } xwk_blk_t;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    xwk_keys_t   keys;
    logic [31:0] dec_sum;
  } xwk_ctrl_t;

  function automatic logic [31:0] xwk_mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic logic [31:0] xwk_feistel(input logic [31:0] x,
                                              input logic [31:0] s,
                                              input logic [31:0] k);
    return xwk_mix(x) ^ (s + k);
  endfunction

endpackage

// ===== rtl/core/xtea_wk_cfg.sv =====
// APB register file: four 64-bit key registers and the round count.
// Also derives the saturated round count and the decrypt start sum. Uses xtea_wk_pkg.
`timescale 1ns / 1ps

module xtea_wk_cfg #(
  parameter int MAX_ROUNDS = 128,
  parameter int RW         = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [xtea_wk_pkg::XWK_ADDR_W-1:0]    paddr,
  input  logic [xtea_wk_pkg::XWK_DATA_W-1:0]    pwdata,
  output logic [xtea_wk_pkg::XWK_DATA_W-1:0]    prdata,
  output logic                                  pready,
  output xtea_wk_pkg::xwk_ctrl_t                ctrl,
  output logic [RW-1:0]                         eff_rounds
);
  import xtea_wk_pkg::*;

  localparam int          RST_EFF = (32 > MAX_ROUNDS) ? MAX_ROUNDS : 32;
  localparam logic [31:0] RST_SUM = 32'(64'(XWK_DELTA) * 64'(RST_EFF));
  localparam logic [7:0]  MAX_N   = 8'(MAX_ROUNDS);

  logic [3:0][63:0] key_r;
  logic [7:0]       rounds_r;
  logic [RW-1:0]    eff_r;
  logic [31:0]      dec_sum_r;
  logic [7:0]       sat_n;
  logic [31:0]      dec_sum_nxt;
  logic [2:0]       idx;
  logic             wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= XWK_ROUNDS_RST;
    end else if (wr_en) begin
      case (idx)
        XWK_REG_KEY_1_0: key_r[0] <= pwdata;
        XWK_REG_KEY_3_2: key_r[1] <= pwdata;
        XWK_REG_KEY_5_4: key_r[2] <= pwdata;
        XWK_REG_KEY_7_6: key_r[3] <= pwdata;
        XWK_REG_ROUNDS:  rounds_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Clamp the incoming round count into 1..MAX_ROUNDS
  always_comb begin
    sat_n = pwdata[7:0];
    if (pwdata[7:0] == 8'd0) begin
      sat_n = 8'd1;
    end else if (pwdata[7:0] > MAX_N) begin
      sat_n = MAX_N;
    end
    dec_sum_nxt = XWK_DELTA * {24'd0, sat_n};
  end

  // Capture the effective count and decrypt start sum with the register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r     <= RW'(RST_EFF);
      dec_sum_r <= RST_SUM;
    end else if (wr_en && idx == XWK_REG_ROUNDS) begin
      eff_r     <= RW'(sat_n);
      dec_sum_r <= dec_sum_nxt;
    end
  end

  always_comb begin
    case (idx)
      XWK_REG_KEY_1_0: prdata = key_r[0];
      XWK_REG_KEY_3_2: prdata = key_r[1];
      XWK_REG_KEY_5_4: prdata = key_r[2];
      XWK_REG_KEY_7_6: prdata = key_r[3];
      XWK_REG_ROUNDS:  prdata = {56'd0, rounds_r};
      default:         prdata = '0;
    endcase
  end

  assign ctrl.keys = {key_r[3][63:32], key_r[3][31:0], key_r[2][63:32], key_r[2][31:0],
                      key_r[1][63:32], key_r[1][31:0], key_r[0][63:32], key_r[0][31:0]};
  assign ctrl.dec_sum = dec_sum_r;
  assign eff_rounds   = eff_r;

endmodule

// ===== rtl/core/xtea_wk_stage.sv =====
// One pipeline stage: half of an XTEA round pair, encrypt or decrypt.
// Passes the block through unchanged once past the configured round count. Uses xtea_wk_pkg.
`timescale 1ns / 1ps

module xtea_wk_stage #(
  parameter int RW          = 8,
  parameter int ROUND_IDX   = 0,
  parameter bit SECOND_HALF = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   valid_in,
  input  xtea_wk_pkg::xwk_blk_t  blk_in,
  input  xtea_wk_pkg::xwk_keys_t keys,
  input  logic [RW-1:0]          eff_rounds,
  output logic                   valid_out,
  output xtea_wk_pkg::xwk_blk_t  blk_out
);
  import xtea_wk_pkg::*;

  localparam logic [RW-1:0] RIDX = RW'(ROUND_IDX);

  logic        valid_r;
  xwk_blk_t    blk_r;
  xwk_blk_t    blk_nxt;
  logic [31:0] k_lo;
  logic [31:0] k_hi;

  assign k_lo = keys[blk_in.sum[2:0]];
  assign k_hi = keys[blk_in.sum[13:11]];

  always_comb begin
    blk_nxt = blk_in;
    if (RIDX < eff_rounds) begin
      if (!SECOND_HALF) begin
        if (blk_in.op == XWK_OP_ENC) begin
          blk_nxt.v0  = blk_in.v0 + xwk_feistel(blk_in.v1, blk_in.sum, k_lo);
          blk_nxt.sum = blk_in.sum + XWK_DELTA;
        end else begin
          blk_nxt.v1  = blk_in.v1 - xwk_feistel(blk_in.v0, blk_in.sum, k_hi);
          blk_nxt.sum = blk_in.sum - XWK_DELTA;
        end
      end else begin
        if (blk_in.op == XWK_OP_ENC) begin
          blk_nxt.v1 = blk_in.v1 + xwk_feistel(blk_in.v0, blk_in.sum, k_hi);
        end else begin
          blk_nxt.v0 = blk_in.v0 - xwk_feistel(blk_in.v1, blk_in.sum, k_lo);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk_r <= blk_nxt;
    end
  end

  assign valid_out = valid_r;
  assign blk_out   = blk_r;

endmodule

// ===== rtl/core/xtea_wide_key_block_cipher_top.sv =====
// Top level of the wide-key XTEA cipher: APB register file and a pipeline
// of 2*MAX_ROUNDS half-round stages. Uses xtea_wk_pkg, xtea_wk_cfg, xtea_wk_stage.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one 64-bit block as two words plus
//   an operation bit (0 encrypt, 1 decrypt). Output channel (out_valid/out_ready)
//   returns one processed block per input transaction, in order.
//   The APB port holds four 64-bit key registers at 0x00..0x18 and the round
//   count at 0x20; write them only while no transaction is in flight.
//   Each accepted block passes through every stage on its way to out_valid,
//   whatever the round count; one half round is done per stage, and stages past
//   the round count pass the block through.
//   Throughput: one transaction per cycle while the output is not stalled, set by the single stage per half round.
//   Reset: pipeline valid bits clear, keys go to zero, round count to 32.
//   Stall: while out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
module xtea_wide_key_block_cipher_top #(
  parameter int MAX_ROUNDS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xtea_wk_pkg::XWK_ADDR_W-1:0] paddr,
  input  logic [xtea_wk_pkg::XWK_DATA_W-1:0] pwdata,
  output logic [xtea_wk_pkg::XWK_DATA_W-1:0] prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [31:0]                        in_word_first,
  input  logic [31:0]                        in_word_second,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        out_result_first,
  output logic [31:0]                        out_result_second
);
  import xtea_wk_pkg::*;

  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int NS = 2 * MAX_ROUNDS;

  xwk_ctrl_t     ctrl;
  logic [RW-1:0] eff_rounds;
  logic          adv;
  logic [NS:0]   valid_s;
  xwk_blk_t      blk_s [NS+1];

  xtea_wk_cfg #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .RW         (RW)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ctrl       (ctrl),
    .eff_rounds (eff_rounds)
  );

  // Hold every stage while the last one has a result nobody takes
  assign adv      = !valid_s[NS] || out_ready;
  assign in_ready = adv;

  assign valid_s[0]   = in_valid;
  assign blk_s[0].op  = in_operation;
  assign blk_s[0].v0  = in_word_first;
  assign blk_s[0].v1  = in_word_second;
  assign blk_s[0].sum = (in_operation == XWK_OP_DEC) ? ctrl.dec_sum : 32'd0;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    xtea_wk_stage #(
      .RW          (RW),
      .ROUND_IDX   (g / 2),
      .SECOND_HALF (1'(g % 2))
    ) u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .valid_in   (valid_s[g]),
      .blk_in     (blk_s[g]),
      .keys       (ctrl.keys),
      .eff_rounds (eff_rounds),
      .valid_out  (valid_s[g+1]),
      .blk_out    (blk_s[g+1])
    );
  end

  assign out_valid         = valid_s[NS];
  assign out_result_first  = blk_s[NS].v0;
  assign out_result_second = blk_s[NS].v1;

endmodule

// ===== tb/xtea_wk_cipher_checker.sv =====
// Result checker for the wide-key XTEA cipher: tracks register writes on the
// APB port, predicts each block on input transactions and compares on output.
// Depends on xtea_wk_pkg for register indexes, operation codes and the delta.
`timescale 1ns / 1ps

module xtea_wk_cipher_checker #(
  parameter int MAX_ROUNDS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xtea_wk_pkg::XWK_ADDR_W-1:0] paddr,
  input  logic [xtea_wk_pkg::XWK_DATA_W-1:0] pwdata,
  input  logic                               pready,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_operation,
  input  logic [31:0]                        in_word_first,
  input  logic [31:0]                        in_word_second,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [31:0]                        out_result_first,
  input  logic [31:0]                        out_result_second,
  output int                                 fail_count,
  output int                                 checked_count,
  output int                                 pending
);
  import xtea_wk_pkg::*;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } block_pair_t;

  logic [31:0] key_word [8];
  logic [7:0]  round_reg;
  block_pair_t expected_blocks [$];
  block_pair_t want;

  initial begin
    fail_count    = 0;
    checked_count = 0;
    pending       = 0;
  end

  function automatic logic [31:0] spread_word(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic block_pair_t crypt_block(input logic op, input logic [31:0] w0,
                                              input logic [31:0] w1);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    int          n;
    block_pair_t res;
    v0 = w0;
    v1 = w1;
    // saturate the round count at both ends
    if (round_reg == 8'd0) n = 1;
    else if (int'(round_reg) > MAX_ROUNDS) n = MAX_ROUNDS;
    else n = int'(round_reg);
    if (op == XWK_OP_ENC) begin
      sum = 32'd0;
      for (int i = 0; i < n; i++) begin
        v0  = v0 + (spread_word(v1) ^ (sum + key_word[sum[2:0]]));
        sum = sum + XWK_DELTA;
        v1  = v1 + (spread_word(v0) ^ (sum + key_word[sum[13:11]]));
      end
    end else begin
      sum = XWK_DELTA * 32'(n);
      for (int i = 0; i < n; i++) begin
        v1  = v1 - (spread_word(v0) ^ (sum + key_word[sum[13:11]]));
        sum = sum - XWK_DELTA;
        v0  = v0 - (spread_word(v1) ^ (sum + key_word[sum[2:0]]));
      end
    end
    res.first  = v0;
    res.second = v1;
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_word[i] = 32'd0;
      round_reg = XWK_ROUNDS_RST;
      expected_blocks.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          XWK_REG_KEY_1_0, XWK_REG_KEY_3_2, XWK_REG_KEY_5_4, XWK_REG_KEY_7_6: begin
            key_word[2 * paddr[4:3]]     = pwdata[31:0];
            key_word[2 * paddr[4:3] + 1] = pwdata[63:32];
          end
          XWK_REG_ROUNDS: round_reg = pwdata[7:0];
          default: ;  // unmapped index: drop the write
        endcase
      end
      if (in_valid && in_ready)
        expected_blocks.insert(expected_blocks.size(),
                               crypt_block(in_operation, in_word_first, in_word_second));
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          report_error($sformatf("unexpected result %08h %08h",
                                 out_result_first, out_result_second));
        end else begin
          want = expected_blocks.pop_front();
          if (out_result_first !== want.first)
            report_error($sformatf("result %0d first word %08h, expected %08h",
                                   checked_count, out_result_first, want.first));
          if (out_result_second !== want.second)
            report_error($sformatf("result %0d second word %08h, expected %08h",
                                   checked_count, out_result_second, want.second));
          checked_count++;
        end
      end
      pending <= expected_blocks.size();
    end
  end

endmodule

// ===== tb/tb_xtea_wide_key_block_cipher_top.sv =====
// Testbench top for xtea_wide_key_block_cipher_top: clock, reset, APB setup,
// bursty block stimulus and the verdict. Uses xtea_wk_pkg and xtea_wk_cipher_checker.
`timescale 1ns / 1ps

module tb_xtea_wide_key_block_cipher_top;
  import xtea_wk_pkg::*;

  localparam int         MAX_ROUNDS   = 128;
  localparam int         TARGET_ITEMS = 800;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [XWK_ADDR_W-1:0] paddr;
  logic [XWK_DATA_W-1:0] pwdata;
  logic [XWK_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [31:0]           in_word_first;
  logic [31:0]           in_word_second;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           out_result_first;
  logic [31:0]           out_result_second;

  int fail_count;
  int checked_count;
  int pending;
  int cycle_count   = 0;
  int burst_left    = 0;
  int sent_items    = 0;
  int enc_items     = 0;
  int dec_items     = 0;
  int settings      = 0;
  int zero_settings = 0;
  int over_settings = 0;
  int ready_left    = 0;
  int ready_pick;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  xtea_wide_key_block_cipher_top #(.MAX_ROUNDS(MAX_ROUNDS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_word_first    (in_word_first),
    .in_word_second   (in_word_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_first (out_result_first),
    .out_result_second(out_result_second)
  );

  xtea_wk_cipher_checker #(.MAX_ROUNDS(MAX_ROUNDS)) u_cipher_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_word_first    (in_word_first),
    .in_word_second   (in_word_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_first (out_result_first),
    .out_result_second(out_result_second),
    .fail_count       (fail_count),
    .checked_count    (checked_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: long ready stretches, stall stretches and coin-flip noise
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_pick = $urandom_range(0, 9);
      if (ready_pick < 5) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(1, 40);
      end else if (ready_pick < 8) begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(1, 12);
      end else begin
        out_ready  <= 1'($urandom_range(0, 1));
        ready_left <= 1;
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [63:0] k10, input logic [63:0] k32,
                              input logic [63:0] k54, input logic [63:0] k76,
                              input logic [7:0] rounds);
    write_register(XWK_REG_KEY_1_0, k10);
    write_register(XWK_REG_KEY_3_2, k32);
    write_register(XWK_REG_KEY_5_4, k54);
    write_register(XWK_REG_KEY_7_6, k76);
    write_register(XWK_REG_ROUNDS, {56'd0, rounds});
    settings++;
    if (rounds == 8'd0) zero_settings++;
    if (int'(rounds) > MAX_ROUNDS) over_settings++;
  endtask

  task automatic send_block(input logic op, input logic [31:0] w0, input logic [31:0] w1);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_word_first  <= w0;
    in_word_second <= w1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (op == XWK_OP_DEC) dec_items++;
    else enc_items++;
  endtask

  task automatic run_pair(input logic [31:0] w0, input logic [31:0] w1);
    send_block(XWK_OP_ENC, w0, w1);
    send_block(XWK_OP_DEC, w0, w1);
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int         n;
    int         pick;
    logic [7:0] rounds;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_operation   = XWK_OP_ENC;
    in_word_first  = 32'd0;
    in_word_second = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero key, 32 rounds
    run_pair(32'h0000_0000, 32'h0000_0000);
    run_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_pair(32'h0000_0000, 32'hFFFF_FFFF);
    run_pair(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    load_setting(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 8'd1);
    run_pair(32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // zero rounds saturate to one
    load_setting(64'hA5A5_A5A5_5A5A_5A5A, 64'h0123_4567_89AB_CDEF,
                 64'hFEDC_BA98_7654_3210, 64'h8000_0000_0000_0001, 8'd0);
    run_pair(32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();

    load_setting(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, MAX_ROUNDS[7:0]);
    run_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // counts above the maximum saturate to it
    load_setting(64'd0, ALL_ONES, 64'd0, ALL_ONES, 8'd255);
    run_pair(32'h8000_0000, 32'h0000_0001);
    wait_drained();

    load_setting(ALL_ONES, 64'd0, ALL_ONES, 64'd0, 8'd129);
    // writes past the register list must not disturb anything
    write_register(REG_SPARE_LO, ALL_ONES);
    write_register(REG_SPARE_HI, 64'h0000_0000_0000_0005);
    run_pair(32'h7FFF_FFFF, 32'hFFFF_FFFE);
    wait_drained();

    while (sent_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) rounds = 8'($urandom_range(1, MAX_ROUNDS));
      else if (pick == 7) rounds = ($urandom_range(0, 1) == 1) ? 8'd1 : MAX_ROUNDS[7:0];
      else if (pick == 8) rounds = 8'd0;
      else rounds = 8'($urandom_range(MAX_ROUNDS + 1, 255));
      load_setting({pick_word(), pick_word()}, {pick_word(), pick_word()},
                   {pick_word(), pick_word()}, {pick_word(), pick_word()}, rounds);
      n = $urandom_range(10, 100);
      repeat (n) send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
      wait_drained();
    end

    // catch any stray result still coming out of the pipeline
    repeat (2 * MAX_ROUNDS + 64) @(posedge clk);

    $display("ran %0d blocks (%0d encrypt, %0d decrypt), %0d results compared",
             sent_items, enc_items, dec_items, checked_count);
    $display("%0d register settings, %0d with zero rounds, %0d above the maximum",
             settings, zero_settings, over_settings);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
